[sv/fpds_pkg.sv]
// Shared types, constants and arithmetic helpers of the flux PLL data separator.
`timescale 1ns / 1ps

package fpds_pkg;

    // Register reset values and limits
    localparam logic [12:0] CENTRE_RST   = 13'd2000;
    localparam logic [6:0]  PGAIN_RST    = 7'd5;
    localparam logic [6:0]  HGAIN_RST    = 7'd60;
    localparam logic [13:0] PERIOD_RST   = 14'd2000;
    localparam logic [12:0] CENTRE_MIN   = 13'd1000;
    localparam logic [12:0] CENTRE_MAX   = 13'd8000;
    localparam logic [6:0]  PCT_MAX      = 7'd100;

    // Loop behavior
    localparam int          MAX_ADJ_PCT  = 10;
    localparam int          SYNC_ZEROS   = 3;
    localparam int          MAX_RESULTS  = 48;
    localparam logic [3:0]  ZERO_RUN_MAX = 4'd15;
    localparam logic [13:0] CELL_MAX     = 14'd16383;
    localparam int          RES_MAX      = 65535;

    // Period clamp factors, applied to the centre before dividing by 100
    localparam logic [20:0] LO_MUL = 21'(100 - MAX_ADJ_PCT);
    localparam logic [20:0] HI_MUL = 21'(100 + MAX_ADJ_PCT);

    // floor(x / 100) = (x * DIV100_M) >> DIV100_SH, exact for x below 2^20
    localparam logic [19:0] DIV100_M  = 20'd671089;
    localparam int          DIV100_SH = 26;

    // Queue depths
    localparam int MID_DEPTH = 2;
    localparam int OUT_DEPTH = 2;

    typedef enum logic [1:0] {
        REG_CENTRE = 2'd0,
        REG_PGAIN  = 2'd1,
        REG_HGAIN  = 2'd2
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TEST,
        ST_BIT,
        ST_MUL,
        ST_DIV,
        ST_UPD
    } t_back_state;

    typedef struct packed {
        logic [14:0] interval_ns;
        logic        restart;
    } t_item;

    typedef struct packed {
        logic        data_bit;
        logic        last;
        logic [13:0] cell_ns;
    } t_result;

    typedef struct packed {
        logic [12:0] centre_period_ns;
        logic [6:0]  period_gain_pct;
        logic [6:0]  phase_gain_pct;
    } t_cfg;

    typedef struct packed {
        logic [14:0] interval_ns;
        logic        restart;
        logic [12:0] centre;
        logic [6:0]  pgain;
        logic [6:0]  hgain;
        logic [13:0] lo;
        logic [13:0] hi;
    } t_job;

    typedef struct packed {
        logic        load;
        logic [13:0] period;
    } t_period_load;

    function automatic logic [12:0] eff_centre(input logic [12:0] c);
        logic [12:0] r;
        r = c;
        if (c < CENTRE_MIN) r = CENTRE_MIN;
        if (c > CENTRE_MAX) r = CENTRE_MAX;
        return r;
    endfunction

    function automatic logic [6:0] sat_pct(input logic [6:0] p);
        return (p > PCT_MAX) ? PCT_MAX : p;
    endfunction

    function automatic logic [14:0] div100(input logic [20:0] x);
        logic [40:0] p;
        p = {20'b0, x} * {21'b0, DIV100_M};
        return p[DIV100_SH +: 15];
    endfunction

endpackage

[sv/fpds_fifo.sv]
// Small register queue used between the front end, the cell engine and the result port.
`timescale 1ns / 1ps

module fpds_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count,  n_count;
    logic             s_push, s_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign s_push  = i_push && !o_full;
    assign s_pop   = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (s_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (s_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (s_push && !s_pop) begin
            n_count = r_count + 1'b1;
        end else if (s_pop && !s_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

[sv/fpds_front.sv]
// Front end: captures each interval with its settings and works out the period clamp window.
`timescale 1ns / 1ps

module fpds_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  fpds_pkg::t_item i_item,
    input  logic            i_push,
    output logic            o_full,
    input  fpds_pkg::t_cfg  i_cfg,
    output fpds_pkg::t_job  o_job,
    output logic            o_job_push,
    input  logic            i_job_full
);

    logic        r_v1, r_v2;
    logic        s_en;
    logic [12:0] s_centre;
    logic [14:0] s_lo_q, s_hi_q;

    // stage 1
    logic [14:0] r_interval;
    logic        r_restart;
    logic [12:0] r_centre;
    logic [6:0]  r_pgain, r_hgain;
    logic [20:0] r_lo_p, r_hi_p;

    // stage 2
    fpds_pkg::t_job r_job;

    // Advance when the second stage is free or draining into the queue
    assign s_en       = !(r_v2 && i_job_full);
    assign o_full     = !s_en;
    assign o_job_push = r_v2 && !i_job_full;
    assign o_job      = r_job;
    assign s_centre   = fpds_pkg::eff_centre(i_cfg.centre_period_ns);
    assign s_lo_q     = fpds_pkg::div100(r_lo_p);
    assign s_hi_q     = fpds_pkg::div100(r_hi_p);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (s_en) begin
            r_v1 <= i_push;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r_interval <= i_item.interval_ns;
            r_restart  <= i_item.restart;
            r_centre   <= s_centre;
            r_pgain    <= fpds_pkg::sat_pct(i_cfg.period_gain_pct);
            r_hgain    <= fpds_pkg::sat_pct(i_cfg.phase_gain_pct);
            r_lo_p     <= {8'b0, s_centre} * fpds_pkg::LO_MUL;
            r_hi_p     <= {8'b0, s_centre} * fpds_pkg::HI_MUL;

            r_job.interval_ns <= r_interval;
            r_job.restart     <= r_restart;
            r_job.centre      <= r_centre;
            r_job.pgain       <= r_pgain;
            r_job.hgain       <= r_hgain;
            r_job.lo          <= s_lo_q[13:0];
            r_job.hi          <= s_hi_q[13:0];
        end
    end

endmodule

[sv/fpds_back.sv]
// Cell engine: splits each interval into bit cells and tracks period and phase.
`timescale 1ns / 1ps

module fpds_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  fpds_pkg::t_job         i_job,
    input  logic                   i_job_empty,
    output logic                   o_job_pop,
    output fpds_pkg::t_result      o_result,
    output logic                   o_res_push,
    input  logic                   i_res_full,
    input  fpds_pkg::t_period_load i_load
);

    fpds_pkg::t_back_state r_state, n_state;
    fpds_pkg::t_job        r_job, n_job;

    logic [13:0]        r_period,    n_period;
    logic signed [17:0] r_res,       n_res;
    logic [3:0]         r_zero_run,  n_zero_run;
    logic [5:0]         r_count,     n_count;
    logic [13:0]        r_cell,      n_cell;
    logic               r_pend_v,    n_pend_v;
    logic               r_pend_bit,  n_pend_bit;
    logic [13:0]        r_pend_cell, n_pend_cell;
    logic [19:0]        r_pprod,     n_pprod;
    logic [19:0]        r_kprod,     n_kprod;
    logic               r_pneg,      n_pneg;
    logic               r_kneg,      n_kneg;
    logic [12:0]        r_pq,        n_pq;
    logic [12:0]        r_kq,        n_kq;

    logic signed [17:0] s_half;
    logic               s_cont;
    logic signed [17:0] s_base;
    logic signed [18:0] s_sum;
    logic [17:0]        s_mag_r;
    logic signed [14:0] s_diff;
    logic [14:0]        s_mag_d;
    logic               s_sync;
    logic [12:0]        s_mag_p;
    logic [6:0]         s_keep_pct;
    logic signed [15:0] s_pdelta;
    logic signed [15:0] s_pnew;
    logic signed [17:0] s_kept;
    logic signed [18:0] s_cellv;
    logic [14:0]        s_pq_full;
    logic [14:0]        s_kq_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= fpds_pkg::ST_IDLE;
            r_period   <= fpds_pkg::PERIOD_RST;
            r_res      <= '0;
            r_zero_run <= '0;
            r_count    <= '0;
            r_pend_v   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_period   <= n_period;
            r_res      <= n_res;
            r_zero_run <= n_zero_run;
            r_count    <= n_count;
            r_pend_v   <= n_pend_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job       <= n_job;
        r_cell      <= n_cell;
        r_pend_bit  <= n_pend_bit;
        r_pend_cell <= n_pend_cell;
        r_pprod     <= n_pprod;
        r_kprod     <= n_kprod;
        r_pneg      <= n_pneg;
        r_kneg      <= n_kneg;
        r_pq        <= n_pq;
        r_kq        <= n_kq;
    end

    // Shared arithmetic
    assign s_half     = $signed({5'b0, r_period[13:1]});
    assign s_cont     = (r_count < 6'(fpds_pkg::MAX_RESULTS)) && (r_res >= s_half);
    assign s_base     = i_job.restart ? 18'sd0 : r_res;
    assign s_sum      = {s_base[17], s_base} + $signed({4'b0, i_job.interval_ns});
    assign s_mag_r    = r_res[17] ? 18'(-r_res) : 18'(r_res);
    assign s_diff     = $signed({2'b0, r_job.centre}) - $signed({1'b0, r_period});
    assign s_mag_d    = s_diff[14] ? 15'(-s_diff) : 15'(s_diff);
    assign s_sync     = (r_zero_run <= 4'(fpds_pkg::SYNC_ZEROS));
    assign s_mag_p    = s_sync ? s_mag_r[12:0] : s_mag_d[12:0];
    assign s_keep_pct = fpds_pkg::PCT_MAX - r_job.hgain;
    assign s_pdelta   = r_pneg ? -$signed({3'b0, r_pq}) : $signed({3'b0, r_pq});
    assign s_pnew     = $signed({2'b0, r_period}) + s_pdelta;
    assign s_kept     = r_kneg ? -$signed({5'b0, r_kq}) : $signed({5'b0, r_kq});
    assign s_cellv    = $signed({5'b0, r_cell}) + {r_res[17], r_res} - {s_kept[17], s_kept};
    assign s_pq_full  = fpds_pkg::div100({1'b0, r_pprod});
    assign s_kq_full  = fpds_pkg::div100({1'b0, r_kprod});

    always_comb begin
        n_state     = r_state;
        n_job       = r_job;
        n_period    = r_period;
        n_res       = r_res;
        n_zero_run  = r_zero_run;
        n_count     = r_count;
        n_cell      = r_cell;
        n_pend_v    = r_pend_v;
        n_pend_bit  = r_pend_bit;
        n_pend_cell = r_pend_cell;
        n_pprod     = r_pprod;
        n_kprod     = r_kprod;
        n_pneg      = r_pneg;
        n_kneg      = r_kneg;
        n_pq        = r_pq;
        n_kq        = r_kq;
        o_job_pop   = 1'b0;
        o_res_push  = 1'b0;

        o_result.data_bit = r_pend_bit;
        o_result.last     = !s_cont;
        o_result.cell_ns  = r_pend_cell;

        unique case (r_state)
            fpds_pkg::ST_IDLE: begin
                if (!i_job_empty) begin
                    o_job_pop = 1'b1;
                    n_job     = i_job;
                    if (i_job.restart) begin
                        n_period   = {1'b0, i_job.centre};
                        n_zero_run = '0;
                    end
                    // saturate the accumulated phase at the top
                    if (s_sum > 19'(fpds_pkg::RES_MAX)) begin
                        n_res = 18'(fpds_pkg::RES_MAX);
                    end else begin
                        n_res = s_sum[17:0];
                    end
                    n_count = '0;
                    n_state = fpds_pkg::ST_TEST;
                end
            end
            fpds_pkg::ST_TEST: begin
                // hold while a finished cell cannot be handed on
                if (!(r_pend_v && i_res_full)) begin
                    o_res_push = r_pend_v;
                    n_pend_v   = 1'b0;
                    if (s_cont) begin
                        n_res   = r_res - $signed({4'b0, r_period});
                        n_cell  = r_period;
                        n_count = r_count + 1'b1;
                        n_state = fpds_pkg::ST_BIT;
                    end else begin
                        n_state = fpds_pkg::ST_IDLE;
                    end
                end
            end
            fpds_pkg::ST_BIT: begin
                if (r_res >= s_half) begin
                    if (r_zero_run != fpds_pkg::ZERO_RUN_MAX) begin
                        n_zero_run = r_zero_run + 1'b1;
                    end
                    n_pend_v    = 1'b1;
                    n_pend_bit  = 1'b0;
                    n_pend_cell = r_cell;
                    n_state     = fpds_pkg::ST_TEST;
                end else begin
                    n_state = fpds_pkg::ST_MUL;
                end
            end
            fpds_pkg::ST_MUL: begin
                n_pprod = {7'b0, s_mag_p} * {13'b0, r_job.pgain};
                n_pneg  = s_sync ? r_res[17] : s_diff[14];
                n_kprod = {7'b0, s_mag_r[12:0]} * {13'b0, s_keep_pct};
                n_kneg  = r_res[17];
                n_state = fpds_pkg::ST_DIV;
            end
            fpds_pkg::ST_DIV: begin
                n_pq    = s_pq_full[12:0];
                n_kq    = s_kq_full[12:0];
                n_state = fpds_pkg::ST_UPD;
            end
            fpds_pkg::ST_UPD: begin
                if (s_pnew < $signed({2'b0, r_job.lo})) begin
                    n_period = r_job.lo;
                end else if (s_pnew > $signed({2'b0, r_job.hi})) begin
                    n_period = r_job.hi;
                end else begin
                    n_period = s_pnew[13:0];
                end
                n_res      = s_kept;
                n_zero_run = '0;
                n_pend_v   = 1'b1;
                n_pend_bit = 1'b1;
                if (s_cellv < 19'sd0) begin
                    n_pend_cell = '0;
                end else if (s_cellv > $signed({5'b0, fpds_pkg::CELL_MAX})) begin
                    n_pend_cell = fpds_pkg::CELL_MAX;
                end else begin
                    n_pend_cell = s_cellv[13:0];
                end
                n_state = fpds_pkg::ST_TEST;
            end
            default: begin
                n_state = fpds_pkg::ST_IDLE;
            end
        endcase

        // a centre write reloads the running period
        if (i_load.load) begin
            n_period = i_load.period;
        end
    end

endmodule

[sv/flux_pll_data_separator_top.sv]
// Top level of the flux PLL data separator: register port, front end, queues and cell engine.
//
//  channel   | direction | handshake              | transfer
//  ----------+-----------+------------------------+-----------------------------------
//  item in   | input     | push / full            | i_item: interval_ns, restart
//  result    | output    | empty / pop            | o_result: data_bit, last, cell_ns
//  registers | input     | psel/penable/pwrite    | paddr 0, 4, 8: centre, period gain,
//            |           | pready always high     | phase gain
//
// An interval passes the front-end registers, then the cell engine loads it in ST_IDLE,
// runs ST_TEST and ST_BIT for each 0 cell, adds ST_MUL, ST_DIV and ST_UPD for each 1 cell,
// and leaves from a closing ST_TEST. The cell engine handles one interval at a time.
// Reset is synchronous, active low, and restores the register defaults and a 2000 ns period.
// A full result queue stalls the cell engine; the front end keeps accepting until the
// middle queue fills, so each side stalls on its own.
`timescale 1ns / 1ps

module flux_pll_data_separator_top #(
    parameter int MID_DEPTH = fpds_pkg::MID_DEPTH,
    parameter int OUT_DEPTH = fpds_pkg::OUT_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // item input
    input  fpds_pkg::t_item   i_item,
    input  logic              push,
    output logic              full,
    // result output
    output fpds_pkg::t_result o_result,
    output logic              empty,
    input  logic              pop,
    // register port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int JOB_W = $bits(fpds_pkg::t_job);
    localparam int RES_W = $bits(fpds_pkg::t_result);

    logic [12:0] r_centre;
    logic [6:0]  r_pgain;
    logic [6:0]  r_hgain;

    logic                   s_wr;
    fpds_pkg::t_reg_idx     s_idx;
    fpds_pkg::t_cfg         s_cfg;
    fpds_pkg::t_period_load s_load;

    fpds_pkg::t_job    s_front_job;
    logic              s_front_push;
    logic              s_mid_full;
    logic [JOB_W-1:0]  s_mid_data;
    logic              s_mid_empty;
    logic              s_mid_pop;

    fpds_pkg::t_result s_back_res;
    logic              s_back_push;
    logic              s_out_full;
    logic [RES_W-1:0]  s_out_data;

    // Register port: zero wait states, write on the access phase
    assign pready = 1'b1;
    assign s_wr   = psel && penable && pwrite && pready;
    assign s_idx  = fpds_pkg::t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_centre <= fpds_pkg::CENTRE_RST;
            r_pgain  <= fpds_pkg::PGAIN_RST;
            r_hgain  <= fpds_pkg::HGAIN_RST;
        end else if (s_wr) begin
            unique case (s_idx)
                fpds_pkg::REG_CENTRE: r_centre <= pwdata[12:0];
                fpds_pkg::REG_PGAIN:  r_pgain  <= pwdata[6:0];
                fpds_pkg::REG_HGAIN:  r_hgain  <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (s_idx)
            fpds_pkg::REG_CENTRE: prdata = {19'b0, r_centre};
            fpds_pkg::REG_PGAIN:  prdata = {25'b0, r_pgain};
            fpds_pkg::REG_HGAIN:  prdata = {25'b0, r_hgain};
            default:              prdata = '0;
        endcase
    end

    assign s_cfg.centre_period_ns = r_centre;
    assign s_cfg.period_gain_pct  = r_pgain;
    assign s_cfg.phase_gain_pct   = r_hgain;

    // A centre write also reloads the running period with the clamped centre
    assign s_load.load   = s_wr && (s_idx == fpds_pkg::REG_CENTRE);
    assign s_load.period = {1'b0, fpds_pkg::eff_centre(pwdata[12:0])};

    // Front end: capture settings with each interval, derive the clamp window
    fpds_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_item),
        .i_push     (push),
        .o_full     (full),
        .i_cfg      (s_cfg),
        .o_job      (s_front_job),
        .o_job_push (s_front_push),
        .i_job_full (s_mid_full)
    );

    // Decoupling queue between front end and cell engine
    fpds_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_front_push),
        .i_data  (s_front_job),
        .o_full  (s_mid_full),
        .i_pop   (s_mid_pop),
        .o_data  (s_mid_data),
        .o_empty (s_mid_empty)
    );

    // Cell engine
    fpds_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (fpds_pkg::t_job'(s_mid_data)),
        .i_job_empty (s_mid_empty),
        .o_job_pop   (s_mid_pop),
        .o_result    (s_back_res),
        .o_res_push  (s_back_push),
        .i_res_full  (s_out_full),
        .i_load      (s_load)
    );

    // Result queue: the oldest cell waits on o_result while empty is low
    fpds_fifo #(
        .WIDTH (RES_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_back_push),
        .i_data  (s_back_res),
        .o_full  (s_out_full),
        .i_pop   (pop),
        .o_data  (s_out_data),
        .o_empty (empty)
    );

    assign o_result = fpds_pkg::t_result'(s_out_data);

endmodule

[tb/sv/flux_pll_data_separator_top_tb.sv]
// Self-checking testbench for the flux PLL data separator top level.
`timescale 1ns / 1ps

module flux_pll_data_separator_top_tb;
    import fpds_pkg::*;

    localparam int CLK_HALF         = 6;
    localparam int RESET_CYCLES     = 9;
    // Time left for items with no cell to clear the engine after the last expected cell.
    localparam int SETTLE_CYCLES    = 100;
    localparam int HOLD_CYCLES      = 300;
    localparam int TIMEOUT_CYCLES   = 2_000_000;
    localparam int RANDOM_PER_PHASE = 18;
    localparam int PHASES           = 6;
    localparam int DIRECTED_COUNT   = 23;

    // Directed intervals, {interval_ns, restart}, run at the reset settings (2000 ns cell).
    localparam logic [15:0] DIRECTED [DIRECTED_COUNT] = '{
        {15'd4000,  1'b1},   // clean start: one 0 then one 1
        {15'd0,     1'b0},   // nothing to emit, residual only
        {15'd1,     1'b0},
        {15'd999,   1'b0},
        {15'd1000,  1'b0},
        {15'd2000,  1'b0},
        {15'd3000,  1'b0},
        {15'd6000,  1'b0},
        {15'd8000,  1'b0},
        {15'd32767, 1'b0},   // long gap: zero run climbs and saturates
        {15'd32767, 1'b0},
        {15'd4000,  1'b0},   // back in sync: one 0, then a 1 corrected from the residual
        {15'd6000,  1'b0},
        {15'd4000,  1'b0},
        {15'd8000,  1'b0},
        {15'd32767, 1'b1},   // restart combined with the widest interval
        {15'd0,     1'b1},   // restart with nothing to add
        {15'd16384, 1'b0},
        {15'd21845, 1'b0},
        {15'd10922, 1'b0},
        {15'd4100,  1'b0},
        {15'd5900,  1'b0},
        {15'd3900,  1'b0}
    };

    // Predicts the cell stream of the separator and checks it in order.
    class sep_scoreboard;
        int      centre_reg;
        int      pgain_reg;
        int      hgain_reg;
        int      period;
        int      residual;
        int      zero_run;
        t_result cells_due[$];
        int      cells_seen;
        int      errors;

        function void clear();
            centre_reg = int'(CENTRE_RST);
            pgain_reg  = int'(PGAIN_RST);
            hgain_reg  = int'(HGAIN_RST);
            period     = int'(PERIOD_RST);
            residual   = 0;
            zero_run   = 0;
            cells_due.delete();
            cells_seen = 0;
            errors     = 0;
        endfunction

        function int centre_eff();
            int c;
            c = centre_reg;
            if (c < int'(CENTRE_MIN)) c = int'(CENTRE_MIN);
            if (c > int'(CENTRE_MAX)) c = int'(CENTRE_MAX);
            return c;
        endfunction

        function int pct(int p);
            return (p > int'(PCT_MAX)) ? int'(PCT_MAX) : p;
        endfunction

        function void write_reg(t_reg_idx idx, logic [31:0] value);
            case (idx)
                REG_CENTRE: begin
                    centre_reg = int'(value[12:0]);
                    period     = centre_eff();
                end
                REG_PGAIN: pgain_reg = int'(value[6:0]);
                REG_HGAIN: hgain_reg = int'(value[6:0]);
                default: ;
            endcase
        endfunction

        function int pending();
            return cells_due.size();
        endfunction

        // Run one interval through the loop and queue the cells it produces.
        function void note_item(t_item it);
            int      centre;
            int      pg;
            int      hg;
            int      lo;
            int      hi;
            int      cell_len;
            int      kept;
            int      n;
            t_result held;
            centre = centre_eff();
            pg     = pct(pgain_reg);
            hg     = pct(hgain_reg);
            lo     = centre * (100 - MAX_ADJ_PCT) / 100;
            hi     = centre * (100 + MAX_ADJ_PCT) / 100;
            n      = 0;
            held   = '0;
            if (it.restart) begin
                period   = centre;
                residual = 0;
                zero_run = 0;
            end
            residual = residual + int'(it.interval_ns);
            if (residual > RES_MAX) residual = RES_MAX;
            while (n < MAX_RESULTS && period > 0 && residual >= period / 2) begin
                // the previous cell is known not to be the closing one now
                if (n > 0) cells_due.push_back(held);
                cell_len = period;
                residual = residual - period;
                if (residual >= period / 2) begin
                    held.data_bit = 1'b0;
                    if (zero_run < int'(ZERO_RUN_MAX)) zero_run++;
                end else begin
                    if (zero_run <= SYNC_ZEROS)
                        period = period + residual * pg / 100;
                    else
                        period = period + (centre - period) * pg / 100;
                    if (period < lo) period = lo;
                    if (period > hi) period = hi;
                    kept          = residual * (100 - hg) / 100;
                    cell_len      = cell_len + residual - kept;
                    residual      = kept;
                    zero_run      = 0;
                    held.data_bit = 1'b1;
                end
                if (cell_len < 0) cell_len = 0;
                if (cell_len > int'(CELL_MAX)) cell_len = int'(CELL_MAX);
                held.last    = 1'b0;
                held.cell_ns = cell_len[13:0];
                n++;
            end
            if (n > 0) begin
                held.last = 1'b1;
                cells_due.push_back(held);
            end
        endfunction

        task report_error(string msg);
            $display("ERROR: cell %0d: %s", cells_seen, msg);
            errors++;
        endtask

        task check_cell(t_result got);
            t_result want;
            if (cells_due.size() == 0) begin
                report_error($sformatf("unexpected cell bit=%0b last=%0b ns=%0d",
                                       got.data_bit, got.last, got.cell_ns));
            end else begin
                want = cells_due.pop_front();
                if (got.data_bit !== want.data_bit)
                    report_error($sformatf("data_bit got %0b want %0b",
                                           got.data_bit, want.data_bit));
                if (got.last !== want.last)
                    report_error($sformatf("last got %0b want %0b", got.last, want.last));
                if (got.cell_ns !== want.cell_ns)
                    report_error($sformatf("cell_ns got %0d want %0d",
                                           got.cell_ns, want.cell_ns));
            end
            cells_seen++;
        endtask
    endclass

    logic          i_clk;
    logic          i_rst_n;
    t_item         i_item;
    logic          push;
    logic          full;
    t_result       o_result;
    logic          empty;
    logic          pop;
    logic          psel;
    logic          penable;
    logic          pwrite;
    logic [3:0]    paddr;
    logic [31:0]   pwdata;
    logic [31:0]   prdata;
    logic          pready;

    sep_scoreboard sb;
    // Set by the stimulus to make the result side hold off; the receiver takes it and clears it.
    int            rx_hold_cycles;

    flux_pll_data_separator_top u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .push     (push),
        .full     (full),
        .o_result (o_result),
        .empty    (empty),
        .pop      (pop),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Mostly back-to-back or short gaps, now and then a long one.
    function automatic int pick_gap(bit dense);
        int r;
        if (dense) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Most intervals look like MFM (two to four cells with jitter) so the loop
    // stays locked; the rest are short noise or arbitrary gaps up to the maximum.
    function automatic t_item random_item(int centre);
        int    r;
        int    iv;
        t_item it;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            iv         = $urandom_range(2, 4) * centre + $urandom_range(0, centre / 2)
                         - centre / 4;
            it.restart = ($urandom_range(0, 31) == 0);
        end else if (r < 85) begin
            iv         = $urandom_range(0, 3 * centre);
            it.restart = 1'($urandom_range(0, 1));
        end else begin
            iv         = $urandom_range(0, 32767);
            it.restart = 1'($urandom_range(0, 1));
        end
        if (iv < 0) iv = 0;
        if (iv > 32767) iv = 32767;
        it.interval_ns = iv[14:0];
        return it;
    endfunction

    // Register write: setup cycle, then access cycle until pready.
    task automatic write_reg(t_reg_idx idx, logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.write_reg(idx, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Offer one item and hold it until the transfer happens. Leave push high so a
    // following item goes out without a bubble.
    task automatic send_item(t_item it);
        @(negedge i_clk);
        i_item <= it;
        push   <= 1'b1;
        do @(posedge i_clk); while (full);
        sb.note_item(it);
    endtask

    task automatic idle_input(int n);
        if (n > 0) begin
            @(negedge i_clk);
            push <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    task automatic run_random(int count);
        bit dense;
        dense = 1'b0;
        for (int k = 0; k < count; k++) begin
            // switch between gap-free stretches and idling every ten items
            if (k % 10 == 0) dense = ($urandom_range(0, 3) == 0);
            idle_input(pick_gap(dense));
            send_item(random_item(sb.centre_eff()));
        end
    endtask

    // Drop push, wait until every predicted cell has arrived, then let any
    // cell-less items still in flight clear the engine.
    task automatic drain();
        idle_input(1);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Result side: pop with random stalls; a requested hold takes priority.
    initial begin
        int  n;
        int  pops;
        bit  dense;
        pops  = 0;
        dense = 1'b0;
        wait (i_rst_n == 1'b1);
        forever begin
            if (pops % 16 == 0) dense = ($urandom_range(0, 3) == 0);
            if (rx_hold_cycles > 0) begin
                n              = rx_hold_cycles;
                rx_hold_cycles = 0;
            end else begin
                n = pick_gap(dense);
            end
            if (n > 0) begin
                @(negedge i_clk);
                pop <= 1'b0;
                repeat (n - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            pop <= 1'b1;
            @(posedge i_clk);
            if (!empty) begin
                sb.check_cell(o_result);
                pops++;
            end
        end
    end

    // Main sequence: reset, directed intervals, then random phases under
    // several register settings, extremes and out-of-range values among them.
    initial begin
        int          centres [PHASES];
        int          pgains  [PHASES];
        int          hgains  [PHASES];
        logic [15:0] raw;
        i_rst_n        = 1'b0;
        i_item         = '0;
        push           = 1'b0;
        pop            = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        rx_hold_cycles = 0;
        sb             = new();
        sb.clear();

        centres = '{1000, 8000, 8191, 0, 2000, 0};
        pgains  = '{0, 100, 127, 64, 5, 0};
        hgains  = '{0, 100, 127, 1, 60, 0};
        centres[PHASES - 1] = $urandom_range(1000, 8000);
        pgains[PHASES - 1]  = $urandom_range(0, 127);
        hgains[PHASES - 1]  = $urandom_range(0, 127);

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < DIRECTED_COUNT; k++) begin
            raw = DIRECTED[k];
            send_item(t_item'(raw));
        end
        run_random(RANDOM_PER_PHASE);
        drain();

        for (int p = 0; p < PHASES; p++) begin
            write_reg(REG_CENTRE, centres[p]);
            write_reg(REG_PGAIN, pgains[p]);
            write_reg(REG_HGAIN, hgains[p]);
            // Short cells at the minimum centre: stall the result side long
            // enough that both queues fill and full pushes back on the sender.
            if (p == 0) rx_hold_cycles = HOLD_CYCLES;
            run_random(RANDOM_PER_PHASE);
            drain();
        end

        if (sb.errors == 0 && sb.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        repeat (TIMEOUT_CYCLES) @(posedge i_clk);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
